// ----- rtl/cfbed_pkg.sv -----
// Shared types, field offsets and status codes for the CAN frame bit event decoder.
`default_nettype none

package cfbed_pkg;

  // Input tdata layout, lowest bit first
  localparam int unsigned IN_PORT_LSB    = 0;
  localparam int unsigned IN_ID_LSB      = 2;
  localparam int unsigned IN_IDMASK_LSB  = 31;
  localparam int unsigned IN_SLOT_LSB    = 60;
  localparam int unsigned IN_LOB_LSB     = 64;
  localparam int unsigned IN_TMASK_LSB   = 68;
  localparam int unsigned IN_POL_LSB     = 76;
  localparam int unsigned IN_EVA_LSB     = 77;
  localparam int unsigned IN_EVI_LSB     = 81;
  localparam int unsigned IN_PAYLOAD_LSB = 85;
  localparam int unsigned IN_READY_LSB   = 149;
  localparam int unsigned IN_TDATA_W     = 152;

  localparam int unsigned ID_W       = 29;
  localparam int unsigned MATCH_W    = 60;
  localparam int unsigned ACTION_W   = 20;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned RES_W      = 43;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Result status codes
  localparam logic [2:0] ST_BAD_ARG   = 3'd0;
  localparam logic [2:0] ST_BAD_FRAME = 3'd1;
  localparam logic [2:0] ST_NO_MATCH  = 3'd2;
  localparam logic [2:0] ST_UNCHANGED = 3'd3;
  localparam logic [2:0] ST_PUBLISHED = 3'd4;
  localparam logic [2:0] ST_DROPPED   = 3'd5;
  localparam logic [2:0] ST_WRITTEN   = 3'd6;

  localparam logic [4:0] NO_RULE = 5'd16;

  localparam logic OP_WRITE  = 1'b0;

  typedef enum logic [1:0] {
    K_WRITE,
    K_BAD_ARG,
    K_BAD_FRAME,
    K_DECODE
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } bk_state_e;

  // Classified item handed from front to back
  typedef struct packed {
    kind_e            kind;
    logic [1:0]       port;
    logic [ID_W-1:0]  can_id;
    logic [ID_W-1:0]  id_mask;
    logic [3:0]       slot;
    logic [3:0]       lob;
    logic [7:0]       tmask;
    logic             pol;
    logic [3:0]       eva;
    logic [3:0]       evi;
    logic [63:0]      payload;
    logic             sink_ready;
  } item_t;

  // Result item; status sits in the lowest bits
  typedef struct packed {
    logic [ID_W-1:0] pub_value;
    logic            pub_valid;
    logic            level;
    logic [3:0]      event_code;
    logic [4:0]      matched_rule;
    logic [2:0]      status;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/can_frame_bit_event_decoder.sv -----
// CAN frame bit event decoder top level: config register, front, queue and rule scanner.
//
// Usage: items enter on the s_axis channel. tuser selects the operation: 0 stores
// one rule into the table, 1 decodes one received frame. Every item gives exactly one
// result on the m_axis channel, in input order. The active rule count is set through
// cfg_we_i / cfg_wdata_i, by the user only while no item is in flight; not enforced.
//
// Scan: a decode reads one rule per cycle from the table's single read port, in slot
// order from rule 0, and stops at the first match, or after min(count, RULE_SLOTS)
// rules when none matches. Items are scanned one at a time; a rule write or a
// rejected frame goes straight to the result without a scan.
//
// Reset clears the active rule count, every seen flag and recorded level, and all
// handshake state. The rule table itself is not cleared; write rules before use.
//
// Receiver stall: the result waits in the output register, the scanner finishes one
// more item and holds it, and the two-entry queue and the input stage take up to
// three more items before s_axis_tready drops.
`default_nettype none

module can_frame_bit_event_decoder
  import cfbed_pkg::*;
#(
  parameter int unsigned RULE_SLOTS     = 16,
  parameter int unsigned MAX_DATA_BYTES = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration: active rule count
  input  wire logic                   cfg_we_i,
  input  wire logic [4:0]             cfg_wdata_i,
  // Item input
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // port, can_id, id_mask, slot, length_or_byte, test_mask, active_when_set,
  // event_when_active, event_when_inactive, payload, sink_ready, zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation
  input  wire logic                   s_axis_tuser,
  // Result output
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // status, matched_rule, event_code, level_active, publish_valid,
  // publish_value, zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  logic [4:0] active_rules_q;
  logic       push, q_ready, q_valid, q_pop;
  item_t      push_item, head_item;
  result_t    res;

  // Hold the active rule count until the next write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_rules_q <= 5'd0;
    end else if (cfg_we_i) begin
      active_rules_q <= cfg_wdata_i;
    end
  end

  // Front: unpack and classify (write, bad argument, bad frame, decode)
  cfbed_front #(
    .RULE_SLOTS     (RULE_SLOTS),
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_o     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .active_rules_i (active_rules_q),
    .push_o         (push),
    .item_o         (push_item),
    .q_ready_i      (q_ready)
  );

  // Decouple classification from the rule scan
  cfbed_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (head_item),
    .pop_i   (q_pop)
  );

  // Back: table writes, rule scan, result register
  cfbed_back #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .active_rules_i (active_rules_q),
    .q_valid_i      (q_valid),
    .q_item_i       (head_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_res_o      (res),
    .out_ready_i    (m_axis_tready)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - RES_W)'(0), res};

endmodule

`default_nettype wire

// ----- rtl/cfbed_queue.sv -----
// Two-entry queue between the classifying front and the rule scanning back.
`default_nettype none

module cfbed_queue
  import cfbed_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       ready_o,
  output logic       valid_o,
  output item_t      item_o,
  input  wire logic  pop_i
);

  item_t      mem_q [QUEUE_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cfbed_front.sv -----
// Input stage: unpack the stream item, classify it and hold it for the queue.
`default_nettype none

module cfbed_front
  import cfbed_pkg::*;
#(
  parameter int unsigned RULE_SLOTS     = 16,
  parameter int unsigned MAX_DATA_BYTES = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [IN_TDATA_W-1:0] s_tdata_i,
  input  wire logic                  s_tuser_i,
  input  wire logic [4:0]            active_rules_i,
  output logic                       push_o,
  output item_t                      item_o,
  input  wire logic                  q_ready_i
);

  logic  vld_q, vld_d;
  item_t item_q, item_d;
  logic  accept;

  assign s_tready_o = !vld_q || q_ready_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign push_o     = vld_q;
  assign item_o     = item_q;

  always_comb begin
    item_d.port       = s_tdata_i[IN_PORT_LSB +: 2];
    item_d.can_id     = s_tdata_i[IN_ID_LSB +: ID_W];
    item_d.id_mask    = s_tdata_i[IN_IDMASK_LSB +: ID_W];
    item_d.slot       = s_tdata_i[IN_SLOT_LSB +: 4];
    item_d.lob        = s_tdata_i[IN_LOB_LSB +: 4];
    item_d.tmask      = s_tdata_i[IN_TMASK_LSB +: 8];
    item_d.pol        = s_tdata_i[IN_POL_LSB];
    item_d.eva        = s_tdata_i[IN_EVA_LSB +: 4];
    item_d.evi        = s_tdata_i[IN_EVI_LSB +: 4];
    item_d.payload    = s_tdata_i[IN_PAYLOAD_LSB +: 64];
    item_d.sink_ready = s_tdata_i[IN_READY_LSB];

    if (s_tuser_i == OP_WRITE) begin
      // byte index beyond the frame: store a zero mask so the rule never fires
      if (item_d.lob[3]) begin
        item_d.tmask = 8'd0;
      end
      item_d.kind = (32'(item_d.slot) >= RULE_SLOTS) ? K_BAD_ARG : K_WRITE;
    end else if (active_rules_i == 5'd0) begin
      item_d.kind = K_BAD_ARG;
    end else if (item_d.port[1] || (32'(item_d.lob) > MAX_DATA_BYTES)) begin
      item_d.kind = K_BAD_FRAME;
    end else begin
      item_d.kind = K_DECODE;
    end

    vld_d = accept ? 1'b1 : (q_ready_i ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cfbed_back.sv -----
// Rule table and sequential scan: one rule read per cycle, first match wins.
`default_nettype none

module cfbed_back
  import cfbed_pkg::*;
#(
  parameter int unsigned RULE_SLOTS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [4:0] active_rules_i,
  input  wire logic       q_valid_i,
  input  wire item_t      q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  output result_t         out_res_o,
  input  wire logic       out_ready_i
);

  localparam int unsigned SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(RULE_SLOTS + 1);

  bk_state_e state_q, state_d;

  logic [MATCH_W-1:0]  match_mem [RULE_SLOTS];
  logic [ACTION_W-1:0] action_mem [RULE_SLOTS];
  logic                seen_q [RULE_SLOTS];
  logic                last_q [RULE_SLOTS];

  item_t              item_q;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]   scan_idx_q, scan_idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0]  rd_idx_q;
  logic [MATCH_W-1:0] rd_match_q;
  logic [ACTION_W-1:0] rd_action_q;
  result_t            res_q, res_d;
  logic               out_vld_q, out_vld_d;
  result_t            out_q;

  logic              issue, out_free, out_load, pop_item;
  logic              mem_we, upd_en;
  logic [SLOT_W-1:0] wr_idx;

  logic [ID_W-1:0] rd_rid, rd_rmask;
  logic [1:0]      rd_rport;
  logic [2:0]      rd_byte;
  logic [7:0]      rd_bmask, rd_sel;
  logic            rd_pol, bit_hit, level, rule_hit;
  logic [3:0]      rd_eva, rd_evi, ev;

  assign issue    = (state_q == BK_SCAN) && (scan_idx_q < n_q);
  assign out_free = !out_vld_q || out_ready_i;
  assign wr_idx   = SLOT_W'(q_item_i.slot);
  assign pop_item = (state_q == BK_IDLE) && q_valid_i;

  // Decode the rule held in the read registers against the current frame
  always_comb begin
    rd_rid   = rd_match_q[ID_W-1:0];
    rd_rmask = rd_match_q[2*ID_W-1:ID_W];
    rd_rport = rd_match_q[MATCH_W-1:MATCH_W-2];
    rd_byte  = rd_action_q[2:0];
    rd_bmask = rd_action_q[10:3];
    rd_pol   = rd_action_q[11];
    rd_eva   = rd_action_q[15:12];
    rd_evi   = rd_action_q[19:16];
    rd_sel   = item_q.payload[{rd_byte, 3'b000} +: 8];
    bit_hit  = |(rd_sel & rd_bmask);
    level    = rd_pol ? bit_hit : !bit_hit;
    ev       = level ? rd_eva : rd_evi;
    rule_hit = rd_vld_q && (rd_rport == item_q.port) &&
               (((item_q.can_id ^ rd_rid) & rd_rmask) == '0) &&
               ({1'b0, rd_byte} < item_q.lob) && (rd_bmask != 8'd0);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_item_i.kind == K_DECODE) ? BK_SCAN : BK_EMIT;
        end
      end
      BK_SCAN: begin
        if (rule_hit || (!rd_vld_q && !issue)) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and table control
  always_comb begin
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    upd_en     = 1'b0;
    out_load   = 1'b0;
    res_d      = res_q;
    n_d        = n_q;
    scan_idx_d = scan_idx_q;
    rd_vld_d   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o    = 1'b1;
          res_d      = '0;
          res_d.matched_rule = NO_RULE;
          scan_idx_d = '0;
          n_d = (32'(active_rules_i) < RULE_SLOTS) ? CNT_W'(active_rules_i)
                                                   : CNT_W'(RULE_SLOTS);
          case (q_item_i.kind)
            K_WRITE: begin
              mem_we             = 1'b1;
              res_d.status       = ST_WRITTEN;
              res_d.matched_rule = 5'(q_item_i.slot);
            end
            K_BAD_ARG:   res_d.status = ST_BAD_ARG;
            K_BAD_FRAME: res_d.status = ST_BAD_FRAME;
            default:     res_d.status = ST_NO_MATCH;
          endcase
        end
      end
      BK_SCAN: begin
        rd_vld_d = issue && !rule_hit;
        if (issue) begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
        if (rule_hit) begin
          res_d.matched_rule = 5'(rd_idx_q);
          res_d.level        = level;
          res_d.event_code   = ev;
          if (ev == 4'd0) begin
            res_d.status = ST_UNCHANGED;
            upd_en       = 1'b1;
          end else if (seen_q[rd_idx_q] && (last_q[rd_idx_q] == level)) begin
            res_d.status = ST_UNCHANGED;
          end else if (item_q.sink_ready) begin
            res_d.status    = ST_PUBLISHED;
            res_d.pub_valid = 1'b1;
            res_d.pub_value = item_q.can_id;
            upd_en          = 1'b1;
          end else begin
            res_d.status = ST_DROPPED;
          end
        end
      end
      BK_EMIT: begin
        out_load = out_free;
      end
      default: ;
    endcase
    out_vld_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < RULE_SLOTS; i++) begin
        seen_q[i] <= 1'b0;
        last_q[i] <= 1'b0;
      end
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      if (mem_we) begin
        seen_q[wr_idx] <= 1'b0;
        last_q[wr_idx] <= 1'b0;
      end else if (upd_en) begin
        seen_q[rd_idx_q] <= 1'b1;
        last_q[rd_idx_q] <= level;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    n_q        <= n_d;
    scan_idx_q <= scan_idx_d;
    if (pop_item) begin
      item_q <= q_item_i;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Rule tables: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      match_mem[wr_idx]  <= {q_item_i.port, q_item_i.id_mask, q_item_i.can_id};
      action_mem[wr_idx] <= {q_item_i.evi, q_item_i.eva, q_item_i.pol,
                             q_item_i.tmask, q_item_i.lob[2:0]};
    end
    if (issue) begin
      rd_idx_q    <= scan_idx_q[SLOT_W-1:0];
      rd_match_q  <= match_mem[scan_idx_q[SLOT_W-1:0]];
      rd_action_q <= action_mem[scan_idx_q[SLOT_W-1:0]];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

// ----- tb/sv/can_frame_bit_event_decoder_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the CAN frame bit event decoder: rule writes and frame decodes.
module can_frame_bit_event_decoder_tb;
  import cfbed_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYC  = 24;   // longest scan plus pipeline, with margin
  localparam logic        OP_DECODE   = 1'b1;

  // One input item, all fields; fields that an operation ignores still get values
  typedef struct {
    logic            op;
    logic [1:0]      port;
    logic [ID_W-1:0] can_id;
    logic [ID_W-1:0] id_mask;
    logic [3:0]      slot;
    logic [3:0]      lob;
    logic [7:0]      tmask;
    logic            pol;
    logic [3:0]      eva;
    logic [3:0]      evi;
    logic [63:0]     payload;
    logic            sink_ready;
  } can_item_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [4:0]            cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Shadow copy of the rule table and its level tracking
  logic [1:0]      rule_port    [SLOTS];
  logic [ID_W-1:0] rule_id      [SLOTS];
  logic [ID_W-1:0] rule_id_mask [SLOTS];
  logic [2:0]      rule_byte_idx[SLOTS];
  logic [7:0]      rule_bit_mask[SLOTS];
  logic            rule_pol     [SLOTS];
  logic [3:0]      rule_ev_on   [SLOTS];
  logic [3:0]      rule_ev_off  [SLOTS];
  logic            rule_seen    [SLOTS];
  logic            rule_level   [SLOTS];
  logic [4:0]      rules_in_use;

  result_t     pending_results[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int          rx_hold_cycles;
  bit          tx_idle_en;
  bit          rx_idle_en;

  can_frame_bit_event_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("can_frame_bit_event_decoder test failed");
      $finish;
    end
  end

  // Result side: random stalls, an optional long hold-off, or always ready
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_cycles = rx_hold_cycles - 1;
      end else if (!rx_idle_en) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 35);
      end
    end
  end

  // Compare every result transfer against the oldest prediction
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RES_W-1:0];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %h with nothing pending", got);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.matched_rule != want.matched_rule ||
            got.event_code != want.event_code || got.level != want.level ||
            got.pub_valid != want.pub_valid || got.pub_value != want.pub_value) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected st %0d rule %0d ev %0d lvl %0b pub %0b/%h,",
                      " got st %0d rule %0d ev %0d lvl %0b pub %0b/%h"},
                     want.status, want.matched_rule, want.event_code, want.level,
                     want.pub_valid, want.pub_value, got.status, got.matched_rule,
                     got.event_code, got.level, got.pub_valid, got.pub_value);
        end
      end
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_item(can_item_t it);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_PORT_LSB    +: 2]    = it.port;
    d[IN_ID_LSB      +: ID_W] = it.can_id;
    d[IN_IDMASK_LSB  +: ID_W] = it.id_mask;
    d[IN_SLOT_LSB    +: 4]    = it.slot;
    d[IN_LOB_LSB     +: 4]    = it.lob;
    d[IN_TMASK_LSB   +: 8]    = it.tmask;
    d[IN_POL_LSB]             = it.pol;
    d[IN_EVA_LSB     +: 4]    = it.eva;
    d[IN_EVI_LSB     +: 4]    = it.evi;
    d[IN_PAYLOAD_LSB +: 64]   = it.payload;
    d[IN_READY_LSB]           = it.sink_ready;
    return d;
  endfunction

  // Apply one accepted item to the shadow table and queue the result it must give
  task automatic predict_result(input can_item_t it);
    result_t     res;
    int unsigned scan_len;
    logic        found;
    logic        hit;
    logic        lvl;
    logic [3:0]  ev;
    res              = '0;
    res.matched_rule = NO_RULE;
    found            = 1'b0;
    if (it.op == OP_WRITE) begin
      rule_port[it.slot]     = it.port;
      rule_id[it.slot]       = it.can_id;
      rule_id_mask[it.slot]  = it.id_mask;
      rule_byte_idx[it.slot] = it.lob[2:0];
      // a byte index past the frame end stores a dead rule
      rule_bit_mask[it.slot] = (it.lob > 7) ? 8'd0 : it.tmask;
      rule_pol[it.slot]      = it.pol;
      rule_ev_on[it.slot]    = it.eva;
      rule_ev_off[it.slot]   = it.evi;
      rule_seen[it.slot]     = 1'b0;
      rule_level[it.slot]    = 1'b0;
      res.status             = ST_WRITTEN;
      res.matched_rule       = {1'b0, it.slot};
    end else if (rules_in_use == 0) begin
      res.status = ST_BAD_ARG;
    end else if (it.port > 1 || it.lob > FRAME_BYTES) begin
      res.status = ST_BAD_FRAME;
    end else begin
      res.status = ST_NO_MATCH;
      scan_len   = (rules_in_use < SLOTS) ? rules_in_use : SLOTS;
      for (int r = 0; r < scan_len; r++) begin
        if (!found && rule_port[r] == it.port &&
            ((it.can_id ^ rule_id[r]) & rule_id_mask[r]) == '0 &&
            rule_byte_idx[r] < it.lob && rule_bit_mask[r] != 8'd0) begin
          found            = 1'b1;
          hit              = |(it.payload[8*rule_byte_idx[r] +: 8] & rule_bit_mask[r]);
          lvl              = rule_pol[r] ? hit : !hit;
          ev               = lvl ? rule_ev_on[r] : rule_ev_off[r];
          res.matched_rule = 5'(r);
          res.level        = lvl;
          if (ev == 4'd0) begin
            // no event: record the level anyway
            rule_seen[r]  = 1'b1;
            rule_level[r] = lvl;
            res.status    = ST_UNCHANGED;
          end else if (rule_seen[r] && rule_level[r] == lvl) begin
            res.status     = ST_UNCHANGED;
            res.event_code = ev;
          end else if (it.sink_ready) begin
            rule_seen[r]   = 1'b1;
            rule_level[r]  = lvl;
            res.status     = ST_PUBLISHED;
            res.event_code = ev;
            res.pub_valid  = 1'b1;
            res.pub_value  = it.can_id;
          end else begin
            // sink busy: keep the old level so the change is reported again
            res.status     = ST_DROPPED;
            res.event_code = ev;
          end
        end
      end
    end
    pending_results.push_back(res);
  endtask

  // Offer one item from a falling edge; return at the falling edge after its transfer
  task automatic offer_item(input can_item_t it);
    while (tx_idle_en && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_item(it);
    s_axis_tuser  <= it.op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_result(it);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted result has arrived
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_rule_count(input logic [4:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    rules_in_use  = value;
  endtask

  function automatic can_item_t random_frame();
    can_item_t it;
    it.op         = OP_DECODE;
    it.port       = 2'($urandom_range(3));
    it.can_id     = ID_W'($urandom);
    it.id_mask    = ID_W'($urandom);
    it.slot       = 4'($urandom_range(15));
    it.lob        = 4'($urandom_range(15));
    it.tmask      = 8'($urandom_range(255));
    it.pol        = 1'($urandom_range(1));
    it.eva        = 4'($urandom_range(15));
    it.evi        = 4'($urandom_range(15));
    it.payload    = {$urandom, $urandom};
    it.sink_ready = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic can_item_t make_rule(input logic [3:0] slot, input logic [1:0] port,
                                          input logic [ID_W-1:0] id,
                                          input logic [ID_W-1:0] id_mask,
                                          input logic [3:0] lob, input logic [7:0] tmask,
                                          input logic pol, input logic [3:0] eva,
                                          input logic [3:0] evi);
    can_item_t it;
    it         = random_frame();
    it.op      = OP_WRITE;
    it.slot    = slot;
    it.port    = port;
    it.can_id  = id;
    it.id_mask = id_mask;
    it.lob     = lob;
    it.tmask   = tmask;
    it.pol     = pol;
    it.eva     = eva;
    it.evi     = evi;
    return it;
  endfunction

  function automatic can_item_t make_frame(input logic [1:0] port, input logic [ID_W-1:0] id,
                                           input logic [3:0] dlc, input logic [63:0] payload,
                                           input logic ready);
    can_item_t it;
    it            = random_frame();
    it.port       = port;
    it.can_id     = id;
    it.lob        = dlc;
    it.payload    = payload;
    it.sink_ready = ready;
    return it;
  endfunction

  // Mostly valid ports, sparse or full id masks, mostly live byte masks
  function automatic can_item_t random_rule(input logic [3:0] slot);
    can_item_t it;
    it      = random_frame();
    it.op   = OP_WRITE;
    it.slot = slot;
    it.port = ($urandom_range(9) < 8) ? 2'($urandom_range(1)) : 2'($urandom_range(3, 2));
    case ($urandom_range(3))
      0:       it.id_mask = '0;
      1:       it.id_mask = '1;
      default: it.id_mask = ID_W'($urandom & $urandom);
    endcase
    it.lob   = ($urandom_range(99) < 85) ? 4'($urandom_range(7)) : 4'($urandom_range(15, 8));
    it.tmask = ($urandom_range(9) < 9) ? 8'($urandom_range(255, 1)) : 8'd0;
    it.eva   = ($urandom_range(4) == 0) ? 4'd0 : 4'($urandom_range(15, 1));
    it.evi   = ($urandom_range(4) == 0) ? 4'd0 : 4'($urandom_range(15, 1));
    return it;
  endfunction

  // A frame aimed at one rule in use, well-formed unless that rule's port is invalid;
  // the tested byte is forced low, high or random so the level keeps toggling
  function automatic can_item_t aimed_frame(input int unsigned rule_idx);
    can_item_t   it;
    int unsigned r;
    r = rule_idx;
    if ($urandom_range(1) == 1) r = r & 3;
    it         = random_frame();
    it.port    = rule_port[r];
    it.can_id  = (rule_id[r] & rule_id_mask[r]) | (ID_W'($urandom) & ~rule_id_mask[r]);
    it.lob     = 4'($urandom_range(FRAME_BYTES, rule_byte_idx[r] + 1));
    case ($urandom_range(2))
      0:       it.payload[8*rule_byte_idx[r] +: 8] = 8'h00;
      1:       it.payload[8*rule_byte_idx[r] +: 8] = 8'hFF;
      default: ;
    endcase
    it.sink_ready = ($urandom_range(9) < 7);
    return it;
  endfunction

  function automatic can_item_t next_random_item();
    can_item_t   it;
    int unsigned pick;
    int unsigned scan_len;
    pick     = $urandom_range(99);
    scan_len = (rules_in_use < SLOTS) ? rules_in_use : SLOTS;
    if (pick < 15)
      it = random_rule(4'($urandom_range(SLOTS - 1)));
    else if (pick < 75 && scan_len != 0)
      it = aimed_frame($urandom_range(scan_len - 1));
    else
      it = random_frame();
    return it;
  endfunction

  // Decodes with no rules in use, then load rules 0..7 before any rule is counted
  task automatic test_empty_table();
    offer_item(make_frame(2'd0, 29'h123, 4'd8, 64'h1, 1'b1));
    offer_item(make_frame(2'd3, '1, 4'd15, '1, 1'b1));
    offer_item(make_rule(4'd0, 2'd0, 29'h123, '1, 4'd0, 8'h01, 1'b1, 4'd5, 4'd6));
    offer_item(make_rule(4'd1, 2'd1, '1, '1, 4'd7, 8'h80, 1'b0, 4'd15, 4'd0));
    offer_item(make_rule(4'd2, 2'd0, '0, '0, 4'd9, 8'hFF, 1'b1, 4'd1, 4'd1));
    offer_item(make_rule(4'd3, 2'd2, '0, '0, 4'd0, 8'hFF, 1'b1, 4'd2, 4'd2));
    offer_item(make_rule(4'd4, 2'd0, '0, '0, 4'd1, 8'h00, 1'b1, 4'd3, 4'd3));
    offer_item(make_rule(4'd5, 2'd0, 29'h100, 29'h100, 4'd2, 8'hFF, 1'b0, 4'd3, 4'd4));
    offer_item(make_rule(4'd6, 2'd1, '0, '0, 4'd3, 8'h0F, 1'b1, 4'd0, 4'd9));
    offer_item(make_rule(4'd7, 2'd0, '0, '0, 4'd0, 8'hFF, 1'b1, 4'd7, 4'd8));
    settle();
  endtask

  // Bad frames, publish, repeat, drop and retry, silent rules, dead rules, no match
  task automatic test_directed_decode();
    write_rule_count(5'd8);
    offer_item(make_frame(2'd2, 29'h123, 4'd8, 64'h1, 1'b1));
    offer_item(make_frame(2'd3, '1, 4'd15, '1, 1'b1));
    offer_item(make_frame(2'd0, 29'h123, 4'd9, 64'h1, 1'b1));
    offer_item(make_frame(2'd0, 29'h123, 4'd8, 64'h1, 1'b1));
    offer_item(make_frame(2'd0, 29'h123, 4'd8, 64'h1, 1'b1));
    offer_item(make_frame(2'd0, 29'h123, 4'd1, 64'h0, 1'b0));
    offer_item(make_frame(2'd0, 29'h123, 4'd1, 64'h0, 1'b1));
    offer_item(make_frame(2'd1, '1, 4'd8, '1, 1'b1));
    offer_item(make_frame(2'd1, '0, 4'd4, 64'h0, 1'b1));
    offer_item(make_frame(2'd0, 29'h100, 4'd3, 64'h0, 1'b1));
    offer_item(make_frame(2'd0, '1, 4'd0, '1, 1'b1));
    offer_item(make_frame(2'd0, '0, 4'd1, 64'h0, 1'b0));
    settle();
  endtask

  // Fill the whole table, then run random traffic under several rule counts
  task automatic test_random_traffic();
    logic [4:0] counts[8];
    counts = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd17, 5'd0, 5'd12, 5'd16};
    for (int s = 0; s < SLOTS; s++) offer_item(random_rule(4'(s)));
    settle();
    foreach (counts[p]) begin
      write_rule_count(counts[p]);
      repeat (80) offer_item(next_random_item());
      settle();
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    write_rule_count(5'd16);
    tx_idle_en     = 1'b0;
    rx_hold_cycles = 300;
    repeat (40) offer_item(next_random_item());
    tx_idle_en = 1'b1;
    settle();
  endtask

  // Back-to-back transfers on both sides
  task automatic test_idle_free_stretch();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (120) offer_item(next_random_item());
    settle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_WRITE;
    mismatch_count = 0;
    cycle_count    = 0;
    rx_hold_cycles = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    rules_in_use   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      rule_seen[s]  = 1'b0;
      rule_level[s] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_directed_decode();
    test_random_traffic();
    test_backpressure();
    test_idle_free_stretch();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("can_frame_bit_event_decoder test passed");
    end else begin
      $display("can_frame_bit_event_decoder test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cfbed_pkg.sv
rtl/cfbed_queue.sv
rtl/cfbed_front.sv
rtl/cfbed_back.sv
rtl/can_frame_bit_event_decoder.sv
tb/sv/can_frame_bit_event_decoder_tb.sv
